[sv/mtfc_pkg.sv]
// ----------------------------------------------------------------------------
// mtfc_pkg
// Shared types and constants of the musical time format converter.
// ----------------------------------------------------------------------------
`default_nettype none

package mtfc_pkg;

  // register indexes of the configuration port
  typedef enum logic [1:0] {
    REG_BEATS_PER_MEASURE = 2'd0,
    REG_BEAT_UNIT         = 2'd1,
    REG_TICKS_PER_QUARTER = 2'd2
  } reg_idx_t;

  // conversion direction
  localparam logic ACT_TO_PACKED = 1'b0;
  localparam logic ACT_TO_TICKS  = 1'b1;

  // error codes
  localparam logic [1:0] ERR_OK       = 2'd0;
  localparam logic [1:0] ERR_ZERO_DIV = 2'd1;
  localparam logic [1:0] ERR_OVERFLOW = 2'd2;

  // reset values of the configuration registers
  localparam logic [4:0] RST_BEATS_PER_MEASURE = 5'd4;
  localparam logic [7:0] RST_BEAT_UNIT         = 8'd4;
  localparam logic [7:0] RST_TICKS_PER_QUARTER = 8'd96;

  // ticks per beat division: 10 quotient bits over two stages
  localparam int TPB_STEPS = 5;

  // measure division: 32 quotient bits over the divider stages
  localparam int DIV_STEPS  = 4;
  localparam int DIV_STAGES = 32 / DIV_STEPS;

  // beat quotient is below beats per measure, so five bits
  localparam int BEAT_BITS = 5;

  // front end stage: ticks per beat division in progress
  typedef struct packed {
    logic        vld;
    logic        act;
    logic [31:0] tv;
    logic [4:0]  bpm;
    logic [7:0]  bu;
    logic [9:0]  dq;
    logic [7:0]  rem;
  } front_t;

  // main pipeline beat: measure division in progress
  typedef struct packed {
    logic        vld;
    logic        act;
    logic        zero;
    logic [9:0]  tpb;
    logic [14:0] tpm;
    logic [31:0] tv;
    logic [31:0] dq;
    logic [14:0] rem;
  } pipe_t;

  // back end stage: split values and reverse products
  typedef struct packed {
    logic        vld;
    logic        act;
    logic        zero;
    logic        ovf;
    logic [15:0] meas;
    logic [BEAT_BITS-1:0] beat;
    logic [11:0] tick;
    logic [30:0] pm;
    logic [13:0] pb;
  } back_t;

endpackage

`default_nettype wire

[sv/mtfc_front.sv]
// ----------------------------------------------------------------------------
// mtfc_front
// Entry stages: ticks per beat by restoring division over two stages, then
// ticks per measure and the zero divisor check.
// ----------------------------------------------------------------------------
`default_nettype none

module mtfc_front
  import mtfc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        vld,
  input  wire logic        act,
  input  wire logic [31:0] tv,
  input  wire logic [4:0]  bpm,
  input  wire logic [7:0]  bu,
  input  wire logic [7:0]  tpq,
  output pipe_t            q
);

  front_t s1_r, s1_nxt;
  front_t s2_r, s2_nxt;
  pipe_t  s3_r, s3_nxt;

  // five restoring steps on a front beat
  function automatic front_t tpb_steps(front_t f);
    front_t    o;
    logic [8:0] r9;
    o = f;
    for (int k = 0; k < TPB_STEPS; k++) begin
      r9   = {o.rem, o.dq[9]};
      o.dq = {o.dq[8:0], 1'b0};
      if (r9 >= {1'b0, o.bu}) begin
        o.rem   = 8'(r9 - {1'b0, o.bu});
        o.dq[0] = 1'b1;
      end else begin
        o.rem = r9[7:0];
      end
    end
    return o;
  endfunction

  always_comb begin
    front_t f0;
    f0.vld = vld;
    f0.act = act;
    f0.tv  = tv;
    f0.bpm = bpm;
    f0.bu  = bu;
    f0.dq  = {tpq, 2'b00};
    f0.rem = '0;
    s1_nxt = tpb_steps(f0);
  end

  always_comb begin
    s2_nxt = tpb_steps(s1_r);
  end

  always_comb begin
    s3_nxt.vld  = s2_r.vld;
    s3_nxt.act  = s2_r.act;
    s3_nxt.tpb  = s2_r.dq;
    s3_nxt.tpm  = 15'(s2_r.dq) * 15'(s2_r.bpm);
    s3_nxt.zero = (s2_r.bu == 8'd0) || (s2_r.dq == 10'd0) || (s2_r.bpm == 5'd0);
    s3_nxt.tv   = s2_r.tv;
    s3_nxt.dq   = s2_r.tv;
    s3_nxt.rem  = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.vld <= 1'b0;
      s2_r.vld <= 1'b0;
      s3_r.vld <= 1'b0;
    end else begin
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
      s3_r <= s3_nxt;
    end
  end

  assign q = s3_r;

endmodule

`default_nettype wire

[sv/mtfc_div_stage.sv]
// ----------------------------------------------------------------------------
// mtfc_div_stage
// One stage of the measure divider: a few restoring steps of the tick count
// by ticks per measure, quotient shifted in as the dividend shifts out.
// ----------------------------------------------------------------------------
`default_nettype none

module mtfc_div_stage
  import mtfc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  pipe_t     d,
  output pipe_t     q
);

  pipe_t q_r, q_nxt;

  always_comb begin
    logic [15:0] r16;
    q_nxt = d;
    for (int k = 0; k < DIV_STEPS; k++) begin
      r16      = {q_nxt.rem, q_nxt.dq[31]};
      q_nxt.dq = {q_nxt.dq[30:0], 1'b0};
      if (r16 >= {1'b0, q_nxt.tpm}) begin
        q_nxt.rem   = 15'(r16 - {1'b0, q_nxt.tpm});
        q_nxt.dq[0] = 1'b1;
      end else begin
        q_nxt.rem = r16[14:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.vld <= 1'b0;
    end else begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

`default_nettype wire

[sv/mtfc_back.sv]
// ----------------------------------------------------------------------------
// mtfc_back
// Exit stages: beat and tick split plus reverse products, then packing,
// reverse sum and error code into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mtfc_back
  import mtfc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  pipe_t            d,
  output logic             out_vld,
  output logic [31:0]      out_res,
  output logic [1:0]       out_err
);

  back_t       b_r, b_nxt;
  logic        vld_r;
  logic [31:0] res_r, res_nxt;
  logic [1:0]  err_r, err_nxt;

  // beat is below beats per measure, so a shifted divisor per bit suffices
  always_comb begin
    logic [14:0] r;
    logic [14:0] dsh;
    logic [BEAT_BITS-1:0] bt;
    r  = d.rem;
    bt = '0;
    for (int i = BEAT_BITS - 1; i >= 0; i--) begin
      dsh = 15'(d.tpb) << i;
      if (r >= dsh) begin
        r     = r - dsh;
        bt[i] = 1'b1;
      end
    end
    b_nxt.vld  = d.vld;
    b_nxt.act  = d.act;
    b_nxt.zero = d.zero;
    b_nxt.ovf  = (d.dq[31:16] != 16'd0);
    b_nxt.meas = d.dq[15:0];
    b_nxt.beat = bt;
    b_nxt.tick = (d.act == ACT_TO_TICKS) ? d.tv[11:0] : {2'b00, r[9:0]};
    b_nxt.pm   = 31'(d.tv[31:16]) * 31'(d.tpm);
    b_nxt.pb   = 14'(d.tv[15:12]) * 14'(d.tpb);
  end

  always_comb begin
    logic [32:0] sum;
    sum = 33'(b_r.pm) + 33'(b_r.pb) + 33'(b_r.tick);
    if (b_r.zero) begin
      res_nxt = '0;
      err_nxt = ERR_ZERO_DIV;
    end else if (b_r.act == ACT_TO_TICKS) begin
      res_nxt = sum[31:0];
      err_nxt = sum[32] ? ERR_OVERFLOW : ERR_OK;
    end else begin
      res_nxt = {b_r.meas, b_r.beat[3:0], b_r.tick};
      err_nxt = (b_r.ovf || b_r.beat[4]) ? ERR_OVERFLOW : ERR_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_r.vld <= 1'b0;
      vld_r   <= 1'b0;
    end else begin
      b_r   <= b_nxt;
      vld_r <= b_r.vld;
      res_r <= res_nxt;
      err_r <= err_nxt;
    end
  end

  assign out_vld = vld_r;
  assign out_res = res_r;
  assign out_err = err_r;

endmodule

`default_nettype wire

[sv/midi_time_format_converter.sv]
// ----------------------------------------------------------------------------
// midi_time_format_converter
// Converts between absolute tick counts and packed measure/beat/tick words.
// ----------------------------------------------------------------------------
// One conversion enters per clock cycle and its result leaves in order, on
// out_valid for a single cycle; the receiver cannot hold results off. The
// result passes the measure divider, which resolves four quotient bits per
// stage over eight stages, behind three entry stages that derive ticks per
// beat and per measure, and ahead of two exit stages. busy is always low.
// Each item uses the configuration present when it is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module midi_time_format_converter
  import mtfc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_action,
  input  wire logic [31:0] in_time_value,
  output logic             out_valid,
  output logic [31:0]      out_result_value,
  output logic [1:0]       out_error_code,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);

  logic [4:0] bpm_r;
  logic [7:0] bu_r;
  logic [7:0] tpq_r;

  pipe_t div_p [0:DIV_STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpm_r <= RST_BEATS_PER_MEASURE;
      bu_r  <= RST_BEAT_UNIT;
      tpq_r <= RST_TICKS_PER_QUARTER;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BEATS_PER_MEASURE: bpm_r <= cfg_data[4:0];
        REG_BEAT_UNIT:         bu_r  <= cfg_data;
        REG_TICKS_PER_QUARTER: tpq_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  mtfc_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .vld   (start && !busy),
    .act   (in_action),
    .tv    (in_time_value),
    .bpm   (bpm_r),
    .bu    (bu_r),
    .tpq   (tpq_r),
    .q     (div_p[0])
  );

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    mtfc_div_stage u_div (
      .clk   (clk),
      .rst_n (rst_n),
      .d     (div_p[g]),
      .q     (div_p[g+1])
    );
  end

  mtfc_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .d       (div_p[DIV_STAGES]),
    .out_vld (out_valid),
    .out_res (out_result_value),
    .out_err (out_error_code)
  );

endmodule

`default_nettype wire

[bench/mtfc_checker.sv]
// ----------------------------------------------------------------------------
// mtfc_checker
// Watches the configuration port and both channels of the musical time format
// converter. It keeps its own copy of the time signature and resolution,
// computes the conversion of every accepted input beat, and compares each
// result beat field by field against the oldest pending conversion.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mtfc_checker
  import mtfc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic        in_action,
  input  wire logic [31:0] in_time_value,
  input  wire logic        out_valid,
  input  wire logic [31:0] out_result_value,
  input  wire logic [1:0]  out_error_code,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data,
  output int               fail_count,
  output int               pending
);

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  err;
  } conversion_t;

  conversion_t expected_conversions[$];

  logic [4:0] bpm_q = RST_BEATS_PER_MEASURE;
  logic [7:0] bu_q  = RST_BEAT_UNIT;
  logic [7:0] tpq_q = RST_TICKS_PER_QUARTER;

  function automatic conversion_t convert_time(logic act, logic [31:0] tv, logic [4:0] bpm,
                                               logic [7:0] bu, logic [7:0] tpq);
    logic [31:0] tpb;
    logic [31:0] tpm;
    logic [31:0] meas;
    logic [31:0] rem;
    logic [31:0] beat;
    logic [31:0] tick;
    logic [63:0] sum;
    conversion_t r;
    r   = '0;
    tpb = (bu == 8'd0) ? 32'd0 : ({24'd0, tpq} * 32'd4) / {24'd0, bu};
    tpm = tpb * {27'd0, bpm};
    if (tpb == 32'd0 || tpm == 32'd0) begin
      r.err = ERR_ZERO_DIV;
    end else if (act == ACT_TO_PACKED) begin
      meas = tv / tpm;
      rem  = tv % tpm;
      beat = rem / tpb;
      tick = rem % tpb;
      r.err = ERR_OK;
      if (meas > 32'hFFFF) r.err = ERR_OVERFLOW;
      if (beat > 32'hF) r.err = ERR_OVERFLOW;
      r.value = {meas[15:0], beat[3:0], tick[11:0]};
    end else begin
      sum = tv[11:0] + tv[15:12] * tpb + tv[31:16] * tpm;
      r.err = (sum > 64'hFFFF_FFFF) ? ERR_OVERFLOW : ERR_OK;
      r.value = sum[31:0];
    end
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin
    conversion_t exp_c;
    if (!rst_n) begin
      bpm_q <= RST_BEATS_PER_MEASURE;
      bu_q  <= RST_BEAT_UNIT;
      tpq_q <= RST_TICKS_PER_QUARTER;
      expected_conversions.delete();
    end else begin
      if (out_valid) begin
        if (expected_conversions.size() == 0) begin
          report_mismatch($sformatf("result beat %h err %0d with nothing pending",
                                    out_result_value, out_error_code));
        end else begin
          exp_c = expected_conversions.pop_front();
          if (out_result_value !== exp_c.value)
            report_mismatch($sformatf("result_value %h, expected %h",
                                      out_result_value, exp_c.value));
          if (out_error_code !== exp_c.err)
            report_mismatch($sformatf("error_code %0d, expected %0d",
                                      out_error_code, exp_c.err));
        end
      end
      if (start && !busy)
        expected_conversions.push_back(convert_time(in_action, in_time_value,
                                                    bpm_q, bu_q, tpq_q));
      if (cfg_we) begin
        case (cfg_index)
          REG_BEATS_PER_MEASURE: bpm_q <= cfg_data[4:0];
          REG_BEAT_UNIT:         bu_q  <= cfg_data;
          REG_TICKS_PER_QUARTER: tpq_q <= cfg_data;
          default: ;
        endcase
      end
    end
    pending <= expected_conversions.size();
  end

endmodule

`default_nettype wire

[bench/midi_time_format_converter_tb.sv]
// ----------------------------------------------------------------------------
// midi_time_format_converter_tb
// Drives the musical time format converter through directed corner cases
// (field extremes, zero ticks per beat or measure, measure and beat
// truncation) and then random conversions under a series of time signatures,
// including the extremes. Start is idled at random; the checker beside the
// block predicts and compares every result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module midi_time_format_converter_tb;
  import mtfc_pkg::*;

  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam int SETTLE_CYCLES = 20;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_action = ACT_TO_PACKED;
  logic [31:0] in_time_value = '0;
  logic        out_valid;
  logic [31:0] out_result_value;
  logic [1:0]  out_error_code;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;
  int          fail_count;
  int          pending;

  bit burst = 1'b0;
  int cur_bpm = RST_BEATS_PER_MEASURE;
  int cur_tpb = 96;
  int cur_tpm = 384;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  midi_time_format_converter u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_action        (in_action),
    .in_time_value    (in_time_value),
    .out_valid        (out_valid),
    .out_result_value (out_result_value),
    .out_error_code   (out_error_code),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  mtfc_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_action        (in_action),
    .in_time_value    (in_time_value),
    .out_valid        (out_valid),
    .out_result_value (out_result_value),
    .out_error_code   (out_error_code),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  task automatic send(logic act, logic [31:0] tv);
    int  gap;
    logic stalled;
    gap = burst ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    in_action     <= act;
    in_time_value <= tv;
    do begin
      @(negedge clk);
      stalled = busy;
      @(posedge clk);
    end while (stalled);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic configure(int bpm, int bu, int tpq);
    wait_idle();
    write_reg(REG_SPARE, 8'($urandom));
    write_reg(REG_BEATS_PER_MEASURE, {3'($urandom), 5'(bpm)});
    write_reg(REG_BEAT_UNIT, 8'(bu));
    write_reg(REG_TICKS_PER_QUARTER, 8'(tpq));
    cfg_we  <= 1'b0;
    cur_bpm = bpm;
    cur_tpb = (bu == 0) ? 0 : (tpq * 4) / bu;
    cur_tpm = cur_tpb * bpm;
  endtask

  task automatic send_random();
    int          sel;
    logic [15:0] meas;
    logic [3:0]  beat;
    logic [11:0] tick;
    sel = $urandom_range(0, 9);
    if (sel < 2 || cur_tpm == 0) begin
      send(1'($urandom), $urandom);
    end else if (sel < 6) begin
      if (sel == 2)
        send(ACT_TO_PACKED, $urandom_range(0, cur_tpm * 300));
      else
        send(ACT_TO_PACKED, $urandom_range(0, cur_tpm * 66000));
    end else begin
      meas = (sel < 8) ? 16'($urandom) : 16'($urandom_range(0, 300));
      beat = 4'($urandom_range(0, (cur_bpm > 16) ? 15 : cur_bpm - 1));
      tick = 12'($urandom_range(0, (cur_tpb > 4096) ? 4095 : cur_tpb - 1));
      send(ACT_TO_TICKS, {meas, beat, tick});
    end
  endtask

  initial begin
    int bu;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reset signature 4/4 at 96 ticks per quarter
    send(ACT_TO_PACKED, 32'd0);
    send(ACT_TO_PACKED, 32'd383);
    send(ACT_TO_PACKED, 32'd384);
    send(ACT_TO_PACKED, 32'hFFFF_FFFF);
    send(ACT_TO_TICKS, 32'd0);
    send(ACT_TO_TICKS, 32'hFFFF_FFFF);
    send(ACT_TO_TICKS, 32'h0002_305F);

    // one tick per beat, 31 beats: beat truncation
    configure(31, 128, 32);
    send(ACT_TO_PACKED, 32'd30);
    send(ACT_TO_PACKED, 32'd20);
    send(ACT_TO_TICKS, 32'h0001_F000);
    send(ACT_TO_TICKS, 32'hFFFF_FFFF);

    // largest ticks per measure
    configure(31, 1, 255);
    send(ACT_TO_PACKED, 32'hFFFF_FFFF);
    send(ACT_TO_TICKS, 32'hFFFF_FFFF);

    // zero ticks per beat or per measure
    configure(4, 255, 1);
    send(ACT_TO_PACKED, 32'd1234);
    send(ACT_TO_TICKS, 32'd1234);
    configure(0, 4, 96);
    send(ACT_TO_PACKED, 32'd1234);
    send(ACT_TO_TICKS, 32'hFFFF_FFFF);
    configure(4, 0, 96);
    send(ACT_TO_PACKED, 32'd500);
    configure(4, 4, 0);
    send(ACT_TO_TICKS, 32'd500);

    for (int p = 0; p < 9; p++) begin
      case (p)
        0: configure(1, 1, 1);
        1: configure(16, 255, 255);
        2: configure(31, 1, 255);
        3: configure(0, $urandom_range(1, 255), $urandom_range(1, 255));
        4: configure($urandom_range(1, 31), 0, $urandom_range(1, 255));
        default: begin
          bu = ($urandom_range(0, 1) == 0) ? (1 << $urandom_range(0, 5))
                                           : $urandom_range(1, 255);
          configure($urandom_range(1, 31), bu, $urandom_range(1, 255));
        end
      endcase
      for (int i = 0; i < 50; i++) begin
        if (i % 10 == 0) burst = ($urandom_range(0, 3) == 0);
        send_random();
      end
      burst = 1'b0;
    end

    wait_idle();
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire

[midi_time_format_converter.f]
sv/mtfc_pkg.sv
sv/mtfc_front.sv
sv/mtfc_div_stage.sv
sv/mtfc_back.sv
sv/midi_time_format_converter.sv
bench/mtfc_checker.sv
bench/midi_time_format_converter_tb.sv
